FILE: src/vlbp_pkg.sv
`default_nettype none
package vlbp_pkg;

  localparam int WORD_BITS = 64;
  localparam int LEN_W = 7;

  localparam logic [LEN_W-1:0] WORD_LEN = LEN_W'(WORD_BITS);

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

endpackage
`default_nettype wire

FILE: src/variable_length_bit_packer_64_unit.sv
// A request is held in the input register; a word it emits goes to the output register.
// Throughput: one request per cycle unless stalled; then in_ready follows out_ready.
// The input register stalls only when it holds a request that emits a word
// while the output register is full and not being taken.
// Reset (synchronous, rst_n low) empties both registers and the pending word.
`default_nettype none
module variable_length_bit_packer_64_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_command,
  input  wire  [vlbp_pkg::WORD_BITS-1:0]   in_code_bits,
  input  wire  [vlbp_pkg::LEN_W-1:0]       in_code_length,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [vlbp_pkg::WORD_BITS-1:0]   out_packed_word,
  output logic                             out_is_partial
);

  logic                            s1_valid_r;
  logic                            s1_cmd_r;
  logic [vlbp_pkg::WORD_BITS-1:0]  s1_code_r;
  logic [vlbp_pkg::LEN_W-1:0]      s1_len_r;

  logic [vlbp_pkg::WORD_BITS-1:0]  pend_r, pend_nxt;
  logic [vlbp_pkg::LEN_W-1:0]      free_r, free_nxt;

  logic                            out_valid_r;
  logic [vlbp_pkg::WORD_BITS-1:0]  out_word_r, out_word_nxt;
  logic                            out_part_r, out_part_nxt;

  logic                            emit;
  logic                            advance;
  logic [vlbp_pkg::LEN_W-1:0]      len_sat;
  logic [vlbp_pkg::WORD_BITS-1:0]  code_m;
  logic [vlbp_pkg::WORD_BITS-1:0]  code_sh;

  always_comb begin
    len_sat = (s1_len_r > vlbp_pkg::WORD_LEN) ? vlbp_pkg::WORD_LEN : s1_len_r;
    code_m  = s1_code_r & ~({vlbp_pkg::WORD_BITS{1'b1}} >> len_sat);
    code_sh = code_m >> (vlbp_pkg::WORD_LEN - free_r);

    emit         = 1'b0;
    pend_nxt     = pend_r;
    free_nxt     = free_r;
    out_word_nxt = pend_r | code_sh;
    out_part_nxt = 1'b0;

    if (s1_cmd_r == vlbp_pkg::CMD_FLUSH) begin
      out_word_nxt = pend_r;
      out_part_nxt = 1'b1;
      if (free_r != vlbp_pkg::WORD_LEN) begin
        emit     = 1'b1;
        pend_nxt = '0;
        free_nxt = vlbp_pkg::WORD_LEN;
      end
    end else if (len_sat != '0) begin
      if (len_sat < free_r) begin
        pend_nxt = pend_r | code_sh;
        free_nxt = free_r - len_sat;
      end else begin
        emit = 1'b1;
        if (len_sat == free_r) begin
          pend_nxt = '0;
          free_nxt = vlbp_pkg::WORD_LEN;
        end else begin
          pend_nxt = code_m << free_r;
          free_nxt = vlbp_pkg::WORD_LEN - (len_sat - free_r);
        end
      end
    end
  end

  assign advance  = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pend_r      <= '0;
      free_r      <= vlbp_pkg::WORD_LEN;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        pend_r <= pend_nxt;
        free_r <= free_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r  <= in_command;
      s1_code_r <= in_code_bits;
      s1_len_r  <= in_code_length;
    end
    if (advance && emit) begin
      out_word_r <= out_word_nxt;
      out_part_r <= out_part_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_word = out_word_r;
  assign out_is_partial  = out_part_r;

endmodule
`default_nettype wire

FILE: src/vlbp_checker.sv
`default_nettype none
module vlbp_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_ready,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire [vlbp_pkg::WORD_BITS-1:0]   out_packed_word,
  input wire                             out_is_partial
);

  // The input side stalls only behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_packed_word) && $stable(out_is_partial)))
    else $error("stalled result changed");

endmodule

bind variable_length_bit_packer_64_unit vlbp_checker u_vlbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_packed_word(out_packed_word),
  .out_is_partial (out_is_partial)
);
`default_nettype wire
